// ----- rtl/core/ctb_pkg.sv -----
// Shared types and constants for the cursor text buffer.
package ctb_pkg;

    localparam int CHAR_W       = 8;
    localparam int CAPACITY_DEF = 64;
    localparam int CAPACITY_MAX = 64;
    // Wide enough for any cell position up to CAPACITY_MAX.
    localparam int POS_W        = $clog2(CAPACITY_MAX + 1);

    typedef enum logic [1:0] {
        KIND_TYPE  = 2'd0,
        KIND_MOVE  = 2'd1,
        KIND_BKSP  = 2'd2,
        KIND_PRINT = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [CHAR_W-1:0]  char_in;
        logic signed [7:0]  distance;
    } in_beat_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  char_out;
        logic               last;
        logic               empty_res;
    } out_beat_t;

    // What every cell of the chain does this cycle.
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [POS_W-1:0]   pos;
        logic [CHAR_W-1:0]  char_in;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/cursor_text_buffer_core.sv -----
// Top level of the cursor text buffer: control, counters and the cell chain.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   s_      | in        | s_valid / s_ready  | s_beat: kind, char_in, distance
//   m_      | out       | m_valid / m_ready  | m_beat: char_out, last, empty_res
//
// Type, move and backspace beats finish in the cycle they are accepted; the
// next beat may follow in the next cycle.
// Print occupies the control until it has emitted one beat per character (one
// beat for an empty buffer), paced by the output register: the chain rotates
// once per emitted beat, so m_ready stalls hold the rotation and s_ready stays low.
// A beat may be accepted while the final print result still waits in the
// output register.
// Reset clears the counters, the control state and m_valid; the cells keep
// whatever they hold, which is never read before it is written.
module cursor_text_buffer_core #(
    parameter int CAPACITY = ctb_pkg::CAPACITY_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ctb_pkg::in_beat_t s_beat,
    output logic              m_valid,
    input  logic              m_ready,
    output ctb_pkg::out_beat_t m_beat
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 9;

    typedef enum logic {
        ST_IDLE,
        ST_PRINT
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           left_reg, left_next;
    logic [CNT_W-1:0]           total_reg, total_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       m_valid_reg, m_valid_next;
    ctb_pkg::out_beat_t         m_beat_reg, m_beat_next;

    ctb_pkg::cell_ctrl_t        ctrl;
    logic [ctb_pkg::CHAR_W-1:0] cell_data [CAPACITY];

    logic                       in_fire;
    logic                       out_free;
    logic                       not_full;
    logic signed [SUM_W-1:0]    move_sum;
    logic signed [SUM_W-1:0]    total_ext;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign not_full = (total_reg < CNT_W'(CAPACITY));

    assign total_ext = $signed({{(SUM_W-CNT_W){1'b0}}, total_reg});
    assign move_sum  = $signed({{(SUM_W-CNT_W){1'b0}}, left_reg})
                     + SUM_W'(s_beat.distance);

    always_comb begin
        state_next   = state_reg;
        left_next    = left_reg;
        total_next   = total_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_beat_next  = m_beat_reg;
        ctrl.op      = ctb_pkg::OP_HOLD;
        ctrl.pos     = '0;
        ctrl.char_in = s_beat.char_in;

        // drop a delivered beat
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (s_beat.kind)
                        ctb_pkg::KIND_TYPE: begin
                            // full buffer: drop the character
                            if (not_full) begin
                                ctrl.op    = ctb_pkg::OP_INSERT;
                                ctrl.pos   = ctb_pkg::POS_W'(left_reg);
                                left_next  = left_reg + 1'b1;
                                total_next = total_reg + 1'b1;
                            end
                        end
                        ctb_pkg::KIND_MOVE: begin
                            // clamp the cursor to both ends of the text
                            if (move_sum < 0) begin
                                left_next = '0;
                            end else if (move_sum > total_ext) begin
                                left_next = total_reg;
                            end else begin
                                left_next = move_sum[CNT_W-1:0];
                            end
                        end
                        ctb_pkg::KIND_BKSP: begin
                            if (left_reg != '0) begin
                                ctrl.op    = ctb_pkg::OP_DELETE;
                                ctrl.pos   = ctb_pkg::POS_W'(left_reg - 1'b1);
                                left_next  = left_reg - 1'b1;
                                total_next = total_reg - 1'b1;
                            end
                        end
                        ctb_pkg::KIND_PRINT: begin
                            cnt_next   = '0;
                            state_next = ST_PRINT;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PRINT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (total_reg == '0) begin
                        m_beat_next.char_out  = '0;
                        m_beat_next.last      = 1'b1;
                        m_beat_next.empty_res = 1'b1;
                        state_next            = ST_IDLE;
                    end else begin
                        // emit the head cell, then rotate the text by one
                        m_beat_next.char_out  = cell_data[0];
                        m_beat_next.last      = (cnt_reg == total_reg - 1'b1);
                        m_beat_next.empty_res = 1'b0;
                        ctrl.op               = ctb_pkg::OP_ROTATE;
                        ctrl.pos              = ctb_pkg::POS_W'(total_reg - 1'b1);
                        cnt_next              = cnt_reg + 1'b1;
                        if (cnt_reg == total_reg - 1'b1) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            left_reg    <= '0;
            total_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            left_reg    <= left_next;
            total_reg   <= total_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        m_beat_reg <= m_beat_next;
    end

    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

    // The chain: cell i holds the i-th character of the text in order.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [ctb_pkg::CHAR_W-1:0] left_nb;
        logic [ctb_pkg::CHAR_W-1:0] right_nb;

        if (i == 0) begin : g_first
            assign left_nb = '0;
        end else begin : g_mid_l
            assign left_nb = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_nb = '0;
        end else begin : g_mid_r
            assign right_nb = cell_data[i+1];
        end

        ctb_cell #(
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .left_data  (left_nb),
            .right_data (right_nb),
            .head_data  (cell_data[0]),
            .data       (cell_data[i])
        );
    end

endmodule

// ----- rtl/core/ctb_cell.sv -----
// One character cell of the text chain.
module ctb_cell #(
    parameter int INDEX = 0
) (
    input  logic                       aclk,
    input  ctb_pkg::cell_ctrl_t        ctrl,
    input  logic [ctb_pkg::CHAR_W-1:0] left_data,
    input  logic [ctb_pkg::CHAR_W-1:0] right_data,
    input  logic [ctb_pkg::CHAR_W-1:0] head_data,
    output logic [ctb_pkg::CHAR_W-1:0] data
);

    localparam logic [ctb_pkg::POS_W-1:0] MY_POS = ctb_pkg::POS_W'(INDEX);

    logic [ctb_pkg::CHAR_W-1:0] data_reg;
    logic [ctb_pkg::CHAR_W-1:0] data_next;
    logic                       at_pos;
    logic                       past_pos;

    assign at_pos   = (MY_POS == ctrl.pos);
    assign past_pos = (MY_POS > ctrl.pos);

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            ctb_pkg::OP_INSERT: begin
                // open a slot at the cursor: cells above take from the left
                if (at_pos) begin
                    data_next = ctrl.char_in;
                end else if (past_pos) begin
                    data_next = left_data;
                end
            end
            ctb_pkg::OP_DELETE: begin
                // close the slot: cells from it upward take from the right
                if (at_pos || past_pos) begin
                    data_next = right_data;
                end
            end
            ctb_pkg::OP_ROTATE: begin
                // rotate the text one place toward cell zero
                if (at_pos) begin
                    data_next = head_data;
                end else if (!past_pos) begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- rtl/core/ctb_checker.sv -----
// Port-level assertions for the cursor text buffer, bound to the top level.
module ctb_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input ctb_pkg::in_beat_t  s_beat,
    input logic               m_valid,
    input logic               m_ready,
    input ctb_pkg::out_beat_t m_beat
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_beat))
        else $error("result beat changed while stalled");

    // an empty print is always a single, final beat
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_beat.empty_res |-> m_beat.last)
        else $error("empty result without last");

    // a print blocks the input on the following cycle
    a_print_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_beat.kind == ctb_pkg::KIND_PRINT |=> !s_ready)
        else $error("input ready right after a print beat");

    // editing beats never produce a result
    a_edit_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_beat.kind != ctb_pkg::KIND_PRINT && !m_valid
        |=> !m_valid)
        else $error("result appeared after an editing beat");

endmodule

bind cursor_text_buffer_core ctb_checker u_ctb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_beat  (s_beat),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_beat  (m_beat)
);
